[sv/rpa_pkg.sv]
`timescale 1ns / 1ps
// Package of the page allocator: field widths, request and status codes,
// the controller state type and the parameter defaults. Depends on nothing.
package rpa_pkg;

  localparam int AddrW    = 24;
  localparam int ReqW     = 3;
  localparam int CfgW     = 12;
  localparam int StatusW  = 2;
  localparam int CountOutW = 8;
  localparam int FreeW    = 13;

  localparam int PageCountDef = 4096;
  localparam int PageShiftDef = 12;
  localparam int CountBitsDef = 8;

  localparam logic [CfgW-1:0] FirstFreeReset = 12'd64;

  typedef enum logic [ReqW-1:0] {
    REQ_INIT  = 3'd0,
    REQ_ALLOC = 3'd1,
    REQ_FREE  = 3'd2,
    REQ_INC   = 3'd3,
    REQ_DEC   = 3'd4,
    REQ_READ  = 3'd5
  } req_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_OOM   = 2'd1,
    ST_BAD   = 2'd2,
    ST_COUNT = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_EXEC  = 4'b0100,
    S_INIT  = 4'b1000
  } state_e;

endpackage

[sv/rpa_ifs.sv]
`timescale 1ns / 1ps
// Channel interfaces of the page allocator: request, result and configuration.
// Depends on rpa_pkg for the field widths.
interface rpa_req_if import rpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ReqW-1:0]   req_type;
  logic [AddrW-1:0]  page_address;

  modport source (output valid, output req_type, output page_address, input ready);
  modport sink   (input valid, input req_type, input page_address, output ready);
endinterface

interface rpa_rsp_if import rpa_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [StatusW-1:0]   status;
  logic [AddrW-1:0]     result_address;
  logic [CountOutW-1:0] ref_count;
  logic [FreeW-1:0]     free_count;

  modport source (output valid, output status, output result_address,
                  output ref_count, output free_count, input ready);
  modport sink   (input valid, input status, input result_address,
                  input ref_count, input free_count, output ready);
endinterface

interface rpa_cfg_if import rpa_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CfgW-1:0] first_free_page;

  modport source (output valid, output first_free_page, input ready);
  modport sink   (input valid, input first_free_page, output ready);
endinterface

[sv/refcounted_page_allocator_top.sv]
`timescale 1ns / 1ps
// Top level of the reference-counted page allocator: controller, count memory
// and free stack memory. Depends on rpa_pkg and the interfaces in rpa_ifs.sv.
//
// Usage: requests arrive on req_i (init, alloc, free, increment, decrement,
// read); each accepted beat yields exactly one result beat on rsp_o carrying
// a status, the allocated address, the page's count and the free page count.
// The first_free_page register is written through cfg_i, which is always
// ready; write it only while no request is in flight.
// After reset the block clears the count memory, one entry per cycle, from
// page 0 up to the last page; req_i.ready stays low during that pass.
// A request other than init is accepted in the idle state, its memory reads
// return in the next cycle, and the result is registered at the end of that
// cycle; the block takes no new request until it is back in the idle state.
// The count and stack memories register their read data.
// Init walks one page per cycle, from first_free_page up to the last page.
// When rsp_o stalls the result waits in the output register, and the next
// request is accepted in the cycle in which that result is taken.
module refcounted_page_allocator_top import rpa_pkg::*; #(
  parameter int PAGE_COUNT = PageCountDef,
  parameter int PAGE_SHIFT = PageShiftDef,
  parameter int COUNT_BITS = CountBitsDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  rpa_cfg_if.sink   cfg_i,
  rpa_req_if.sink   req_i,
  rpa_rsp_if.source rsp_o
);

  localparam int PW = $clog2(PAGE_COUNT);
  localparam int DW = $clog2(PAGE_COUNT + 1);
  localparam logic [31:0]       PageCountW = 32'(PAGE_COUNT);
  localparam logic [PW-1:0]     LastPage   = PW'(PAGE_COUNT - 1);
  localparam logic [DW-1:0]     FullDepth  = DW'(PAGE_COUNT);
  localparam logic [AddrW-1:0]  OffMask    = AddrW'((32'd1 << PAGE_SHIFT) - 32'd1);
  localparam logic [COUNT_BITS-1:0] CntMax = '1;
  localparam logic [COUNT_BITS-1:0] CntOne = COUNT_BITS'(1);

  logic [COUNT_BITS-1:0] cnt_mem [PAGE_COUNT];
  logic [PW-1:0]         stk_mem [PAGE_COUNT];

  state_e                state_q, state_d;
  logic [CfgW-1:0]       ffp_q;
  logic [ReqW-1:0]       req_q;
  logic [PW-1:0]         page_q, page_d;
  logic                  bad_q, bad_d;
  logic [DW-1:0]         depth_q, depth_d;
  logic [PW-1:0]         p_q, p_d;
  logic [COUNT_BITS-1:0] cnt_rd_q;
  logic [PW-1:0]         stk_rd_q;

  logic                  out_valid_q;
  logic [StatusW-1:0]    out_status_q;
  logic [AddrW-1:0]      out_addr_q;
  logic [CountOutW-1:0]  out_cnt_q;
  logic [FreeW-1:0]      out_free_q;

  logic                  req_acc, rd_en, res_load;
  logic                  cnt_we, stk_we;
  logic [PW-1:0]         cnt_wa, stk_wa, pop_idx;
  logic [COUNT_BITS-1:0] cnt_wd, res_cnt;
  logic [PW-1:0]         stk_wd;
  status_e               res_status;
  logic [AddrW-1:0]      res_addr;
  logic                  aligned, in_range, ffp_out;

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = (state_q == S_IDLE) && (!out_valid_q || rsp_o.ready);
  assign req_acc     = req_i.valid && req_i.ready;

  assign aligned  = (req_i.page_address & OffMask) == '0;
  assign in_range = 32'(req_i.page_address >> PAGE_SHIFT) < PageCountW;
  assign page_d   = PW'(req_i.page_address >> PAGE_SHIFT);
  assign bad_d    = !aligned || !in_range ||
                    ((req_i.req_type == REQ_FREE) && (32'(page_d) < 32'(ffp_q)));
  assign pop_idx  = PW'(depth_q - DW'(1));
  assign ffp_out  = 32'(ffp_q) >= PageCountW;

  always_comb begin
    state_d    = state_q;
    depth_d    = depth_q;
    p_d        = p_q;
    rd_en      = 1'b0;
    res_load   = 1'b0;
    cnt_we     = 1'b0;
    cnt_wa     = page_q;
    cnt_wd     = '0;
    stk_we     = 1'b0;
    stk_wa     = depth_q[PW-1:0];
    stk_wd     = page_q;
    res_status = ST_OK;
    res_addr   = '0;
    res_cnt    = '0;
    case (state_q)
      S_CLEAR: begin
        cnt_we = 1'b1;
        cnt_wa = p_q;
        p_d    = p_q + PW'(1);
        if (p_q == LastPage) begin
          p_d     = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_acc) begin
          rd_en = 1'b1;
          if (req_i.req_type == REQ_INIT) begin
            depth_d = '0;
            if (ffp_out) begin
              res_load = 1'b1;
            end else begin
              p_d     = PW'(ffp_q);
              state_d = S_INIT;
            end
          end else begin
            state_d = S_EXEC;
          end
        end
      end
      S_INIT: begin
        cnt_we  = 1'b1;
        cnt_wa  = p_q;
        stk_we  = 1'b1;
        stk_wd  = p_q;
        depth_d = depth_q + DW'(1);
        p_d     = p_q + PW'(1);
        if (p_q == LastPage) begin
          res_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_EXEC: begin
        res_load = 1'b1;
        state_d  = S_IDLE;
        case (req_q)
          REQ_ALLOC: begin
            if (depth_q == '0) begin
              res_status = ST_OOM;
            end else begin
              depth_d  = depth_q - DW'(1);
              cnt_we   = 1'b1;
              cnt_wa   = stk_rd_q;
              cnt_wd   = CntOne;
              res_cnt  = CntOne;
              res_addr = AddrW'(32'(stk_rd_q) << PAGE_SHIFT);
            end
          end
          REQ_FREE: begin
            if (bad_q) begin
              res_status = ST_BAD;
            end else if (cnt_rd_q > CntOne) begin
              cnt_we  = 1'b1;
              cnt_wd  = cnt_rd_q - CntOne;
              res_cnt = cnt_rd_q - CntOne;
            end else begin
              cnt_we = 1'b1;
              if (depth_q != FullDepth) begin
                stk_we  = 1'b1;
                depth_d = depth_q + DW'(1);
              end else begin
                res_status = ST_COUNT;
              end
            end
          end
          REQ_INC: begin
            res_cnt = cnt_rd_q;
            if (bad_q) begin
              res_status = ST_BAD;
              res_cnt    = '0;
            end else if (cnt_rd_q == CntMax) begin
              res_status = ST_COUNT;
            end else begin
              cnt_we  = 1'b1;
              cnt_wd  = cnt_rd_q + CntOne;
              res_cnt = cnt_rd_q + CntOne;
            end
          end
          REQ_DEC: begin
            res_cnt = cnt_rd_q;
            if (bad_q) begin
              res_status = ST_BAD;
              res_cnt    = '0;
            end else if (cnt_rd_q == '0) begin
              res_status = ST_COUNT;
            end else begin
              cnt_we  = 1'b1;
              cnt_wd  = cnt_rd_q - CntOne;
              res_cnt = cnt_rd_q - CntOne;
            end
          end
          REQ_READ: begin
            if (bad_q) begin
              res_status = ST_BAD;
            end else begin
              res_cnt = cnt_rd_q;
            end
          end
          default: begin
            res_status = ST_OK;
          end
        endcase
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    if (rd_en) begin
      cnt_rd_q <= cnt_mem[page_d];
      stk_rd_q <= stk_mem[pop_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      req_q <= req_i.req_type;
      page_q <= page_d;
      bad_q <= bad_d;
    end
    if (res_load) begin
      out_status_q <= res_status;
      out_addr_q   <= res_addr;
      out_cnt_q    <= CountOutW'(res_cnt);
      out_free_q   <= FreeW'(depth_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      depth_q     <= '0;
      p_q         <= '0;
      ffp_q       <= FirstFreeReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      depth_q <= depth_d;
      p_q     <= p_d;
      if (cfg_i.valid && cfg_i.ready) begin
        ffp_q <= cfg_i.first_free_page;
      end
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = out_status_q;
  assign rsp_o.result_address = out_addr_q;
  assign rsp_o.ref_count      = out_cnt_q;
  assign rsp_o.free_count     = out_free_q;

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= FullDepth)
    else $error("free stack depth exceeds the page count");

  a_exec_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EXEC |=> state_q == S_IDLE)
    else $error("execute state did not return to idle");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_EXEC || $past(state_q) == S_INIT
                        || $past(state_q) == S_IDLE)
    else $error("result produced outside a request");

  a_alloc_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_addr_q != '0 |-> out_cnt_q == CountOutW'(1)
                                        && out_status_q == ST_OK)
    else $error("allocated page does not report a count of one");

endmodule

[tb/tb_refcounted_page_allocator_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the reference-counted page allocator top level.
// It depends on rpa_pkg, the channel interfaces in rpa_ifs.sv and the RTL top.
module tb_refcounted_page_allocator_top;
  import rpa_pkg::*;

  localparam logic [ReqW-1:0] REQ_RSVD_LO = 3'd6;
  localparam logic [ReqW-1:0] REQ_RSVD_HI = 3'd7;
  localparam int unsigned CountMax = (1 << CountBitsDef) - 1;
  localparam int unsigned PhaseCount = 10;
  localparam int PageW = $clog2(PageCountDef);

  typedef struct packed {
    logic [ReqW-1:0]  kind;
    logic [AddrW-1:0] addr;
  } page_req_t;

  typedef struct packed {
    logic [StatusW-1:0]   status;
    logic [AddrW-1:0]     addr;
    logic [CountOutW-1:0] count;
    logic [FreeW-1:0]     free;
  } page_result_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_COIN,
    STALL_SPARSE,
    STALL_PERIODIC
  } stall_mode_e;

  logic clk;
  logic rst_n;

  rpa_cfg_if cfg_if ();
  rpa_req_if req_if ();
  rpa_rsp_if rsp_if ();

  refcounted_page_allocator_top u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_if),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  logic [CfgW-1:0]           first_free;
  logic [PageW-1:0]          free_list [PageCountDef];
  int unsigned               free_depth;
  logic [CountOutW-1:0]      page_refs [PageCountDef];

  page_req_t    req_backlog [$];
  page_result_t due_results [$];
  page_req_t    cur_req;
  page_result_t head;

  logic        sending = 1'b0;
  logic        req_taken = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  stall_mode_e stall_mode = STALL_NONE;
  int unsigned stall_left = 0;
  int unsigned stall_period = 2;
  int unsigned stall_tick = 0;

  int unsigned mismatches = 0;
  int unsigned requests_taken = 0;
  int unsigned results_taken = 0;
  int unsigned cfg_writes = 0;
  int unsigned status_hits [4] = '{0, 0, 0, 0};

  logic [CfgW-1:0] ff_plan [PhaseCount];

  function automatic page_result_t predict_page_op(input logic [ReqW-1:0] kind,
                                                   input logic [AddrW-1:0] addr);
    page_result_t r;
    int unsigned  pg;
    int unsigned  p;
    logic         addr_ok;
    r = '0;
    r.status = ST_OK;
    pg = addr >> PageShiftDef;
    addr_ok = (addr[PageShiftDef-1:0] == '0) && (pg < PageCountDef);
    case (kind)
      REQ_INIT: begin
        free_depth = 0;
        for (p = first_free; p < PageCountDef; p++) begin
          page_refs[p] = '0;
          free_list[free_depth] = PageW'(p);
          free_depth++;
        end
      end
      REQ_ALLOC: begin
        if (free_depth == 0) begin
          r.status = ST_OOM;
        end else begin
          free_depth--;
          pg = free_list[free_depth];
          page_refs[pg] = CountOutW'(1);
          r.count = CountOutW'(1);
          r.addr = AddrW'(pg << PageShiftDef);
        end
      end
      REQ_FREE: begin
        if (!addr_ok || pg < first_free) begin
          r.status = ST_BAD;
        end else if (page_refs[pg] > 1) begin
          page_refs[pg] = page_refs[pg] - 1'b1;
          r.count = page_refs[pg];
        end else begin
          page_refs[pg] = '0;
          if (free_depth < PageCountDef) begin
            free_list[free_depth] = PageW'(pg);
            free_depth++;
          end else begin
            r.status = ST_COUNT;
          end
        end
      end
      REQ_INC, REQ_DEC, REQ_READ: begin
        if (!addr_ok) begin
          r.status = ST_BAD;
        end else begin
          if (kind == REQ_INC) begin
            if (page_refs[pg] >= CountMax) r.status = ST_COUNT;
            else page_refs[pg] = page_refs[pg] + 1'b1;
          end else if (kind == REQ_DEC) begin
            if (page_refs[pg] == 0) r.status = ST_COUNT;
            else page_refs[pg] = page_refs[pg] - 1'b1;
          end
          r.count = page_refs[pg];
        end
      end
      default: begin
      end
    endcase
    r.free = FreeW'(free_depth);
    return r;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
    end
  endtask

  task automatic queue_req(input logic [ReqW-1:0] kind, input logic [AddrW-1:0] addr);
    page_req_t item;
    item.kind = kind;
    item.addr = addr;
    req_backlog.push_back(item);
  endtask

  function automatic logic [AddrW-1:0] pick_address(input int unsigned ff);
    logic [AddrW-1:0] a;
    int unsigned      pg;
    int unsigned      sel;
    sel = $urandom_range(0, 99);
    a = AddrW'($urandom_range(0, (1 << AddrW) - 1));
    if (sel < 12) begin
      if (a[PageShiftDef-1:0] == '0) a[0] = 1'b1;
      return a;
    end
    if (sel < 55) pg = PageCountDef - 1 - $urandom_range(0, 23);
    else if (sel < 70) pg = (ff + $urandom_range(0, 7)) % PageCountDef;
    else if (sel < 80) pg = $urandom_range(0, ff) % PageCountDef;
    else pg = $urandom_range(0, PageCountDef - 1);
    a = AddrW'(pg << PageShiftDef);
    return a;
  endfunction

  task automatic plan_phase(input int unsigned ff, input int unsigned count,
                            input int unsigned hammer);
    int unsigned      sel;
    int unsigned      k;
    logic [AddrW-1:0] a;
    queue_req(REQ_INIT, pick_address(ff));
    repeat (count) begin
      sel = $urandom_range(0, 99);
      a = pick_address(ff);
      if (sel < 28) begin
        queue_req(REQ_ALLOC, a);
      end else if (sel < 47) begin
        queue_req(REQ_FREE, a);
      end else if (sel < 62) begin
        queue_req(REQ_INC, a);
      end else if (sel < 72) begin
        queue_req(REQ_DEC, a);
      end else if (sel < 82) begin
        queue_req(REQ_READ, a);
      end else if (sel < 85) begin
        queue_req(REQ_INIT, a);
      end else if (sel < 88) begin
        queue_req(sel[0] ? REQ_RSVD_LO : REQ_RSVD_HI, a);
      end else if (sel < 94) begin
        queue_req(REQ_ALLOC, a);
        queue_req(REQ_FREE, a);
      end else begin
        // A short run of references taken and dropped on one page, with one drop more than takes.
        k = $urandom_range(2, 6);
        repeat (k) queue_req(REQ_INC, a);
        repeat (k + 1) queue_req(REQ_DEC, a);
      end
    end
    if (hammer > 0) begin
      a = AddrW'((PageCountDef - 1 - $urandom_range(0, 3)) << PageShiftDef);
      repeat (hammer) queue_req(REQ_INC, a);
      repeat (3) queue_req(REQ_DEC, a);
      queue_req(REQ_READ, a);
      queue_req(REQ_FREE, a);
    end
  endtask

  task automatic wait_idle();
    while (req_backlog.size() != 0 || sending || due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_first_free(input logic [CfgW-1:0] value);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.first_free_page <= value;
    do @(posedge clk); while (!cfg_if.ready);
    first_free = value;
    cfg_writes++;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    if (req_taken) begin
      req_taken = 1'b0;
      sending = 1'b0;
    end
    if (!sending && rst_n) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (req_backlog.size() > 0) begin
        cur_req = req_backlog.pop_front();
        req_if.req_type <= cur_req.kind;
        req_if.page_address <= cur_req.addr;
        sending = 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
    req_if.valid <= sending;
  end

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_left = $urandom_range(40, 300);
      stall_period = $urandom_range(2, 5);
    end else begin
      stall_left--;
    end
    stall_tick++;
    case (stall_mode)
      STALL_NONE:   rsp_if.ready <= 1'b1;
      STALL_COIN:   rsp_if.ready <= 1'($urandom_range(0, 1));
      STALL_SPARSE: rsp_if.ready <= ($urandom_range(0, 7) == 0);
      default:      rsp_if.ready <= (stall_tick % stall_period == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (rsp_if.valid && rsp_if.ready) begin
        results_taken++;
        if (!$isunknown(rsp_if.status)) status_hits[rsp_if.status]++;
        if (due_results.size() == 0) begin
          mismatches++;
          $display("%0t ns: result beat with nothing expected, actual status 0x%0h addr 0x%0h",
                   $time, rsp_if.status, rsp_if.result_address);
        end else begin
          head = due_results.pop_front();
          check_field("status", head.status, rsp_if.status);
          check_field("result_address", head.addr, rsp_if.result_address);
          check_field("ref_count", head.count, rsp_if.ref_count);
          check_field("free_count", head.free, rsp_if.free_count);
        end
      end
      if (req_if.valid && req_if.ready) begin
        due_results.push_back(predict_page_op(req_if.req_type, req_if.page_address));
        requests_taken++;
        req_taken = 1'b1;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.first_free_page = '0;
    req_if.valid = 1'b0;
    req_if.req_type = REQ_READ;
    req_if.page_address = '0;
    rsp_if.ready = 1'b0;
    first_free = FirstFreeReset;
    free_depth = 0;
    for (int i = 0; i < PageCountDef; i++) page_refs[i] = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Requests on a fresh block, bad addresses and unknown codes.
    queue_req(REQ_READ, 24'h000000);
    queue_req(REQ_ALLOC, 24'h000000);
    queue_req(REQ_DEC, 24'h040000);
    queue_req(REQ_FREE, 24'h000001);
    queue_req(REQ_FREE, 24'h03F000);
    queue_req(REQ_INC, 24'hFFFFFF);
    queue_req(REQ_DEC, 24'h800800);
    queue_req(REQ_READ, 24'h000FFF);
    queue_req(REQ_RSVD_LO, 24'hFFFFFF);
    queue_req(REQ_RSVD_HI, 24'h000000);
    // Shared page dropped reference by reference, then freed twice.
    queue_req(REQ_INIT, 24'h000000);
    queue_req(REQ_ALLOC, 24'h000000);
    queue_req(REQ_INC, 24'hFFF000);
    queue_req(REQ_FREE, 24'hFFF000);
    queue_req(REQ_FREE, 24'hFFF000);
    queue_req(REQ_FREE, 24'hFFF000);
    queue_req(REQ_ALLOC, 24'h000000);
    queue_req(REQ_ALLOC, 24'h000000);
    queue_req(REQ_READ, 24'hFFF000);
    queue_req(REQ_INC, 24'h000000);
    queue_req(REQ_FREE, 24'h040000);
    wait_idle();

    // A free onto a full stack, then a stack holding only the top page.
    write_first_free('0);
    queue_req(REQ_INIT, 24'hFFFFFF);
    queue_req(REQ_FREE, 24'h000000);
    queue_req(REQ_ALLOC, 24'h000000);
    wait_idle();
    write_first_free(CfgW'(PageCountDef - 1));
    queue_req(REQ_INIT, 24'h000000);
    queue_req(REQ_ALLOC, 24'h000000);
    queue_req(REQ_ALLOC, 24'h000000);
    wait_idle();

    ff_plan = '{12'd4032, 12'd4095, 12'd0, 12'd3968, 12'd4064,
                12'd64, 12'd4090, 12'd3900, 12'd0, 12'd4000};
    ff_plan[6] = CfgW'($urandom_range(3968, 4095));
    ff_plan[7] = CfgW'($urandom_range(0, 4095));
    for (int ph = 0; ph < PhaseCount; ph++) begin
      write_first_free(ff_plan[ph]);
      plan_phase(ff_plan[ph], 85, (ph == 3) ? 258 : 0);
      wait_idle();
    end

    repeat (20) @(posedge clk);
    $display("Checked %0d requests and %0d results over %0d register writes.",
             requests_taken, results_taken, cfg_writes);
    $display("Statuses seen: ok %0d, out of memory %0d, bad address %0d, count limit %0d.",
             status_hits[ST_OK], status_hits[ST_OOM], status_hits[ST_BAD], status_hits[ST_COUNT]);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timeout with %0d results still expected", due_results.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
